// ----- src/ubfrq_pkg.sv -----
// Shared types and constants for the USB bulk frame reassembly queue.
package ubfrq_pkg;

    localparam int MAX_FRAME_DEF    = 1514;
    localparam int SLOT_BYTES_DEF   = 2048;
    localparam int QUEUE_SLOTS_DEF  = 4;
    localparam int PACKET_BYTES_DEF = 64;

    localparam int MIN_FRAME = 14;
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 11;
    localparam int EVENT_W   = 2;
    localparam int WAIT_W    = 2;
    localparam int OQ_DEPTH  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_QUEUED = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RUNT   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FULL   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               read_valid;
        logic               read_last;
        logic [LEN_W-1:0]   read_frame_length;
        logic [EVENT_W-1:0] frame_event;
        logic               oversize_discard;
        logic [WAIT_W-1:0]  frames_waiting;
    } t_result;

endpackage

// ----- src/usb_bulk_frame_reassembly_queue.sv -----
// Top level of the USB bulk OUT frame reassembly queue.
// Takes one transaction per clock cycle while the input stall is low: a packet
// byte, an end-of-packet mark or a read of the next stored byte. Every
// transaction yields exactly one result transaction: the item is decoded against
// the ring and assembly registers, while the frame store (one RAM of
// QUEUE_SLOTS * SLOT_BYTES bytes, one write and one read port, registered read)
// is written or read, and the result with the read byte is then registered into
// a three-entry result queue. With the output side taking results every cycle the input
// never stalls; the input stall rises once three results are in flight or waiting.
// The frame store needs no clearing after reset, so the block accepts
// transactions from the first cycle out of reset.
module usb_bulk_frame_reassembly_queue #(
    parameter int MAX_FRAME    = ubfrq_pkg::MAX_FRAME_DEF,
    parameter int SLOT_BYTES   = ubfrq_pkg::SLOT_BYTES_DEF,
    parameter int QUEUE_SLOTS  = ubfrq_pkg::QUEUE_SLOTS_DEF,
    parameter int PACKET_BYTES = ubfrq_pkg::PACKET_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ubfrq_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ubfrq_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ubfrq_pkg::BYTE_W-1:0]  o_read_data,
    output logic                          o_read_valid,
    output logic                          o_read_last,
    output logic [ubfrq_pkg::LEN_W-1:0]   o_read_frame_length,
    output logic [ubfrq_pkg::EVENT_W-1:0] o_frame_event,
    output logic                          o_oversize_discard,
    output logic [ubfrq_pkg::WAIT_W-1:0]  o_frames_waiting
);
    import ubfrq_pkg::*;

    localparam int STORE_DEPTH = QUEUE_SLOTS * SLOT_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic              accept;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              s1_valid;
    t_result           s1_res, push_res, out_res;
    logic              oq_full;

    assign o_in_stall = oq_full;
    assign accept     = i_in_valid && !oq_full;

    ubfrq_ctrl #(
        .MAX_FRAME    (MAX_FRAME),
        .SLOT_BYTES   (SLOT_BYTES),
        .QUEUE_SLOTS  (QUEUE_SLOTS),
        .PACKET_BYTES (PACKET_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1_res)
    );

    ubfrq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // merge the store byte into the result of a read transaction
    always_comb begin
        push_res = s1_res;
        if (s1_res.read_valid) begin
            push_res.read_data = ram_rdata;
        end
    end

    ubfrq_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (s1_valid),
        .i_res     (push_res),
        .i_pending (s1_valid),
        .o_full    (oq_full),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_res     (out_res)
    );

    assign o_read_data         = out_res.read_data;
    assign o_read_valid        = out_res.read_valid;
    assign o_read_last         = out_res.read_last;
    assign o_read_frame_length = out_res.read_frame_length;
    assign o_frame_event       = out_res.frame_event;
    assign o_oversize_discard  = out_res.oversize_discard;
    assign o_frames_waiting    = out_res.frames_waiting;

endmodule

// ----- src/ubfrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ubfrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ubfrq_ctrl.sv -----
// Assembly, ring and read-pointer control; issues the frame store accesses.
module ubfrq_ctrl #(
    parameter int MAX_FRAME    = ubfrq_pkg::MAX_FRAME_DEF,
    parameter int SLOT_BYTES   = ubfrq_pkg::SLOT_BYTES_DEF,
    parameter int QUEUE_SLOTS  = ubfrq_pkg::QUEUE_SLOTS_DEF,
    parameter int PACKET_BYTES = ubfrq_pkg::PACKET_BYTES_DEF,
    parameter int ADDR_W       = $clog2(QUEUE_SLOTS * SLOT_BYTES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [ubfrq_pkg::CMD_W-1:0]  i_cmd,
    output logic                         o_ram_we,
    output logic [ADDR_W-1:0]            o_ram_waddr,
    output logic                         o_ram_re,
    output logic [ADDR_W-1:0]            o_ram_raddr,
    output logic                         o_s1_valid,
    output ubfrq_pkg::t_result           o_s1
);
    import ubfrq_pkg::*;

    localparam int FRAME_LIMIT = (MAX_FRAME < SLOT_BYTES) ? MAX_FRAME : SLOT_BYTES;
    localparam int SLOT_W      = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int PKT_W       = $clog2(PACKET_BYTES + 1);
    localparam int OFF_W       = LEN_W + 1;
    localparam int RING_W      = SLOT_W + 1;

    localparam logic [PKT_W-1:0]  PKT_MAX   = PKT_W'(PACKET_BYTES);
    localparam logic [OFF_W-1:0]  SB_OFF    = OFF_W'(SLOT_BYTES);
    localparam logic [OFF_W-1:0]  LIMIT_OFF = OFF_W'(FRAME_LIMIT);
    localparam logic [LEN_W-1:0]  MIN_LEN   = LEN_W'(MIN_FRAME);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] SB_ADDR   = ADDR_W'(SLOT_BYTES);
    localparam logic [RING_W-1:0] Q_RING    = RING_W'(QUEUE_SLOTS);

    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic [SLOT_W-1:0] r_read_slot, n_read_slot;
    logic [LEN_W-1:0]  r_asm_len, n_asm_len;
    logic [PKT_W-1:0]  r_pkt_cnt, n_pkt_cnt;
    logic [LEN_W-1:0]  r_rd_pos, n_rd_pos;
    logic [LEN_W-1:0]  r_len [QUEUE_SLOTS];
    logic              r_s1_valid;
    t_result           r_s1, n_s1;

    t_cmd              cmd;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  asm_tmp;
    logic              len_we;
    logic [SLOT_W-1:0] next_ws, next_rd;
    logic [LEN_W-1:0]  cur_len;
    logic [OFF_W-1:0]  pos_inc;
    logic [RING_W-1:0] ring_cnt;

    assign cmd     = t_cmd'(i_cmd);
    assign off     = OFF_W'(r_asm_len) + OFF_W'(r_pkt_cnt);
    assign next_ws = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
    assign next_rd = (r_read_slot == LAST_SLOT) ? '0 : r_read_slot + 1'b1;
    assign cur_len = r_len[r_read_slot];
    assign pos_inc = OFF_W'(r_rd_pos) + 1'b1;

    assign o_ram_waddr = ADDR_W'(r_write_slot) * SB_ADDR + ADDR_W'(off);
    assign o_ram_raddr = ADDR_W'(r_read_slot) * SB_ADDR + ADDR_W'(r_rd_pos);

    always_comb begin
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_asm_len    = r_asm_len;
        n_pkt_cnt    = r_pkt_cnt;
        n_rd_pos     = r_rd_pos;
        n_s1         = '0;
        o_ram_we     = 1'b0;
        o_ram_re     = 1'b0;
        len_we       = 1'b0;
        asm_tmp      = '0;
        if (i_accept) begin
            unique case (cmd)
                CMD_BYTE: begin
                    // bytes past the packet size are dropped
                    if (r_pkt_cnt < PKT_MAX) begin
                        o_ram_we  = (off < SB_OFF);
                        n_pkt_cnt = r_pkt_cnt + 1'b1;
                    end
                end
                CMD_END: begin
                    if (off <= LIMIT_OFF) begin
                        asm_tmp = LEN_W'(off);
                    end else begin
                        n_s1.oversize_discard = 1'b1;
                    end
                    // a short packet closes the frame
                    if (r_pkt_cnt < PKT_MAX) begin
                        if (asm_tmp >= MIN_LEN) begin
                            if (next_ws != r_read_slot) begin
                                len_we           = 1'b1;
                                n_write_slot     = next_ws;
                                n_s1.frame_event = EV_QUEUED;
                            end else begin
                                n_s1.frame_event = EV_FULL;
                            end
                        end else begin
                            n_s1.frame_event = EV_RUNT;
                        end
                        n_asm_len = '0;
                    end else begin
                        n_asm_len = asm_tmp;
                    end
                    n_pkt_cnt = '0;
                end
                CMD_READ: begin
                    if (r_read_slot != r_write_slot) begin
                        o_ram_re               = 1'b1;
                        n_s1.read_valid        = 1'b1;
                        n_s1.read_frame_length = cur_len;
                        if (pos_inc >= OFF_W'(cur_len)) begin
                            n_s1.read_last = 1'b1;
                            n_rd_pos       = '0;
                            n_read_slot    = next_rd;
                        end else begin
                            n_rd_pos = LEN_W'(pos_inc);
                        end
                    end
                end
                CMD_NOP: begin
                end
            endcase
        end
        if (n_write_slot >= n_read_slot) begin
            ring_cnt = RING_W'(n_write_slot) - RING_W'(n_read_slot);
        end else begin
            ring_cnt = RING_W'(n_write_slot) + Q_RING - RING_W'(n_read_slot);
        end
        n_s1.frames_waiting = ring_cnt[WAIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_asm_len    <= '0;
            r_pkt_cnt    <= '0;
            r_rd_pos     <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_asm_len    <= n_asm_len;
            r_pkt_cnt    <= n_pkt_cnt;
            r_rd_pos     <= n_rd_pos;
            r_s1_valid   <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        if (len_we) begin
            r_len[r_write_slot] <= asm_tmp;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_read_slot != r_write_slot) |-> (r_rd_pos < r_len[r_read_slot]))
        else $error("read position past stored frame length");

    a_read_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.read_valid) |-> (r_s1.read_frame_length >= MIN_LEN))
        else $error("read returned a frame shorter than the minimum");

    a_last_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && cmd == CMD_READ && r_read_slot != r_write_slot
            && pos_inc >= OFF_W'(cur_len))
        |=> (r_read_slot == $past(next_rd) && r_rd_pos == '0))
        else $error("last byte did not free the slot");

endmodule

// ----- src/ubfrq_outq.sv -----
// Three-entry result queue that decouples the output handshake from the pipeline.
module ubfrq_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ubfrq_pkg::t_result  i_res,
    input  logic                i_pending,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output ubfrq_pkg::t_result  o_res
);
    import ubfrq_pkg::*;

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(OQ_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_C  = (CNT_W + 1)'(OQ_DEPTH);

    t_result           r_ent [OQ_DEPTH];
    logic [PTR_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0]  r_count;
    logic              pop;
    logic [CNT_W:0]    in_flight;

    assign o_valid   = (r_count != '0);
    assign pop       = o_valid && !i_stall;
    assign o_res     = r_ent[r_head];
    // count the result still in the pipeline so it always finds room
    assign in_flight = (CNT_W + 1)'(r_count) + (CNT_W + 1)'(i_pending);
    assign o_full    = (in_flight >= DEPTH_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_tail] <= i_res;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_count < CNT_W'(OQ_DEPTH)))
        else $error("result queue overflow");

endmodule

// ----- tb/sv/usb_bulk_frame_reassembly_queue_test.sv -----
// Self-checking testbench for the USB bulk OUT frame reassembly queue.
`timescale 1ns / 1ps

module usb_bulk_frame_reassembly_queue_test;
    import ubfrq_pkg::*;

    localparam int FRAME_LIMIT = (MAX_FRAME_DEF < SLOT_BYTES_DEF) ? MAX_FRAME_DEF : SLOT_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
        bit                drain;  // hold until every outstanding result has come back
    } t_usb_txn;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_cmd = CMD_NOP;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BYTE_W-1:0]    o_read_data;
    logic                 o_read_valid;
    logic                 o_read_last;
    logic [LEN_W-1:0]     o_read_frame_length;
    logic [EVENT_W-1:0]   o_frame_event;
    logic                 o_oversize_discard;
    logic [WAIT_W-1:0]    o_frames_waiting;

    usb_bulk_frame_reassembly_queue uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_data_byte         (i_data_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_read_data         (o_read_data),
        .o_read_valid        (o_read_valid),
        .o_read_last         (o_read_last),
        .o_read_frame_length (o_read_frame_length),
        .o_frame_event       (o_frame_event),
        .o_oversize_discard  (o_oversize_discard),
        .o_frames_waiting    (o_frames_waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: frame store and ring registers.
    logic [BYTE_W-1:0] frame_mem [QUEUE_SLOTS_DEF*SLOT_BYTES_DEF];
    int unsigned       slot_len [QUEUE_SLOTS_DEF];
    int unsigned       wr_slot = 0;
    int unsigned       rd_slot = 0;
    int unsigned       asm_len = 0;
    int unsigned       pkt_cnt = 0;
    int unsigned       rd_pos = 0;

    t_usb_txn    pending_txns[$];
    t_result     predicted_results[$];
    t_result     predicted;
    t_result     want;
    int unsigned sent_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned items_made = 0;
    int unsigned errors = 0;
    int unsigned in_gap = 0;
    int unsigned out_hold = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;
    t_usb_txn    next_txn;

    int unsigned n_queued = 0, n_runt = 0, n_full = 0, n_oversize = 0;
    int unsigned n_bytes_read = 0, n_empty_reads = 0;

    function automatic t_result reassemble_step(t_cmd c, logic [BYTE_W-1:0] b);
        t_result     r;
        int unsigned nxt;
        int unsigned len;
        r = '0;
        case (c)
            CMD_BYTE: begin
                // ignore bytes past the packet size
                if (pkt_cnt < PACKET_BYTES_DEF) begin
                    if (asm_len + pkt_cnt < SLOT_BYTES_DEF)
                        frame_mem[wr_slot*SLOT_BYTES_DEF + asm_len + pkt_cnt] = b;
                    pkt_cnt++;
                end
            end
            CMD_END: begin
                if (asm_len + pkt_cnt <= FRAME_LIMIT) begin
                    asm_len += pkt_cnt;
                end else begin
                    asm_len = 0;
                    r.oversize_discard = 1'b1;
                end
                // short or zero-length packet closes the frame
                if (pkt_cnt < PACKET_BYTES_DEF) begin
                    if (asm_len >= MIN_FRAME) begin
                        nxt = (wr_slot + 1) % QUEUE_SLOTS_DEF;
                        if (nxt != rd_slot) begin
                            slot_len[wr_slot] = asm_len;
                            wr_slot = nxt;
                            r.frame_event = EV_QUEUED;
                        end else begin
                            r.frame_event = EV_FULL;
                        end
                    end else begin
                        r.frame_event = EV_RUNT;
                    end
                    asm_len = 0;
                end
                pkt_cnt = 0;
            end
            CMD_READ: begin
                if (rd_slot != wr_slot) begin
                    len = slot_len[rd_slot];
                    r.read_frame_length = LEN_W'(len);
                    r.read_valid = 1'b1;
                    r.read_data = frame_mem[rd_slot*SLOT_BYTES_DEF + rd_pos];
                    if (rd_pos + 1 >= len) begin
                        r.read_last = 1'b1;
                        rd_pos = 0;
                        rd_slot = (rd_slot + 1) % QUEUE_SLOTS_DEF;
                    end else begin
                        rd_pos++;
                    end
                end
            end
            default: ;
        endcase
        r.frames_waiting = WAIT_W'((wr_slot + QUEUE_SLOTS_DEF - rd_slot) % QUEUE_SLOTS_DEF);
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic push_txn(t_cmd c, logic [BYTE_W-1:0] d, bit drain);
        t_usb_txn t;
        t.cmd = c;
        t.data = d;
        t.drain = drain;
        pending_txns.push_back(t);
        if (c != CMD_NOP)
            items_made++;
    endtask

    task automatic send_packet(int unsigned n);
        repeat (n) push_txn(CMD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0);
        push_txn(CMD_END, BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // Split a frame into full packets plus a closing short (maybe empty) packet.
    task automatic send_frame(int unsigned len);
        int unsigned left;
        left = len;
        while (left >= PACKET_BYTES_DEF) begin
            if ($urandom_range(0, 7) == 0)
                send_packet(PACKET_BYTES_DEF + $urandom_range(1, 8));
            else
                send_packet(PACKET_BYTES_DEF);
            left -= PACKET_BYTES_DEF;
        end
        send_packet(left);
    endtask

    task automatic send_reads(int unsigned n);
        repeat (n) push_txn(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    // Driver: advance to the next pending transaction once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted = reassemble_step(t_cmd'(i_cmd), i_data_byte);
                predicted_results.push_back(predicted);
                sent_cnt++;
                if (predicted.frame_event == EV_QUEUED) n_queued++;
                if (predicted.frame_event == EV_RUNT) n_runt++;
                if (predicted.frame_event == EV_FULL) n_full++;
                if (predicted.oversize_discard) n_oversize++;
                if (predicted.read_valid) n_bytes_read++;
                else if (i_cmd == CMD_READ) n_empty_reads++;
                in_gap = pick_gap(in_quiet);
            end
            if ($urandom_range(0, 149) == 0)
                in_quiet = !in_quiet;
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_txns.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_txns[0].drain && sent_cnt != results_seen) begin
                    i_in_valid <= 1'b0;
                end else begin
                    next_txn = pending_txns.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd <= next_txn.cmd;
                    i_data_byte <= next_txn.data;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual event %0d data %0d",
                             $time, o_frame_event, o_read_data);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(o_read_data));
                    check_field("read_valid", 32'(want.read_valid), 32'(o_read_valid));
                    check_field("read_last", 32'(want.read_last), 32'(o_read_last));
                    check_field("read_frame_length", 32'(want.read_frame_length),
                                32'(o_read_frame_length));
                    check_field("frame_event", 32'(want.frame_event), 32'(o_frame_event));
                    check_field("oversize_discard", 32'(want.oversize_discard),
                                32'(o_oversize_discard));
                    check_field("frames_waiting", 32'(want.frames_waiting),
                                32'(o_frames_waiting));
                end
                results_seen <= results_seen + 1;
            end
            if ($urandom_range(0, 149) == 0)
                out_quiet = !out_quiet;
            if (out_hold > 0)
                out_hold--;
            else
                out_hold = pick_gap(out_quiet);
            i_out_stall <= (out_hold > 0);
        end
    end

    initial begin
        int unsigned sel;
        int unsigned i;

        // Directed: empty read, no-op, zero-length runt, shortest legal frame, reads.
        push_txn(CMD_READ, 8'hFF, 1'b0);
        push_txn(CMD_NOP, 8'hFF, 1'b0);
        push_txn(CMD_END, 8'h00, 1'b0);
        push_txn(CMD_BYTE, 8'h00, 1'b0);
        push_txn(CMD_BYTE, 8'hFF, 1'b0);
        for (i = 0; i < MIN_FRAME - 2; i++)
            push_txn(CMD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0);
        push_txn(CMD_END, 8'hFF, 1'b0);
        push_txn(CMD_READ, 8'h00, 1'b1);
        send_reads(3);

        // Random: mostly well-formed frames with random content, plus noise.
        while (items_made < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                i = $urandom_range(0, 99);
                if (i < 70)
                    send_frame($urandom_range(MIN_FRAME, 70));
                else if (i < 85)
                    send_frame($urandom_range(0, MIN_FRAME - 1));
                else if (i < 92)
                    send_frame(PACKET_BYTES_DEF * $urandom_range(1, 3));
                else
                    send_frame($urandom_range(65, 200));
            end else if (sel < 75) begin
                send_reads($urandom_range(1, 80));
            end else if (sel < 83) begin
                send_packet($urandom_range(0, 80));
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 6))
                    push_txn(t_cmd'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                             1'b0);
            end else if (sel < 95) begin
                push_txn(CMD_NOP, BYTE_W'($urandom_range(0, 255)), 1'b0);
            end else begin
                push_txn(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
        end

        // Close any open assembly after every outstanding result is back.
        push_txn(CMD_END, 8'h00, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_txns.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     predicted_results.size());
            errors++;
        end

        $display("Ran %0d transactions: %0d frames queued, %0d runts, %0d ring-full drops,",
                 sent_cnt, n_queued, n_runt, n_full);
        $display("%0d oversize discards, %0d bytes read back, %0d empty reads, %0d checked",
                 n_oversize, n_bytes_read, n_empty_reads, results_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ubfrq_pkg.sv
src/ubfrq_ram.sv
src/ubfrq_ctrl.sv
src/ubfrq_outq.sv
src/usb_bulk_frame_reassembly_queue.sv
tb/sv/usb_bulk_frame_reassembly_queue_test.sv
